// File: rtl/sorted_deadline_timer_queue_top_assert.svh
// assertion macros for the sorted deadline timer queue
`ifndef SORTED_DEADLINE_TIMER_QUEUE_TOP_ASSERT_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, reset masks the check
`define SDTQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define SDTQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sdtq_pkg.sv
// shared constants, types and helpers of the sorted deadline timer queue
`default_nettype none
package sdtq_pkg;

  localparam int unsigned QD_DEPTH_DEF = 16;
  localparam int unsigned MAX_RESULTS  = 16;
  localparam int unsigned POP_W        = $clog2(MAX_RESULTS);
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned TOUT_W       = 24;
  localparam int unsigned TAG_W        = 16;

  localparam logic FUNC_ADD     = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;
  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_EXPIRED = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_FULL  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  // one stored event
  typedef struct packed {
    logic [TIME_W-1:0] dl;
    logic [TAG_W-1:0]  tag;
  } ent_t;

  // insert wave passed from cell to cell
  typedef struct packed {
    logic              vld;
    logic              shift;
    logic [TIME_W-1:0] dl;
    logic [TAG_W-1:0]  tag;
  } carry_t;

  // deadline at or before t, signed distance
  function automatic logic is_due(input logic [TIME_W-1:0] dl, input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] d;
    d = dl - t;
    return (d == '0) || d[TIME_W-1];
  endfunction

endpackage
`default_nettype wire

// File: rtl/sdtq_if.sv
// input and result channel interfaces of the sorted deadline timer queue
`default_nettype none
interface sdtq_in_if import sdtq_pkg::*;;
  logic              valid;
  logic              ready;
  logic              func;
  logic [TOUT_W-1:0] timeout;
  logic [TAG_W-1:0]  event_tag;

  modport source (output valid, output func, output timeout, output event_tag, input ready);
  modport sink   (input valid, input func, input timeout, input event_tag, output ready);
endinterface

interface sdtq_out_if import sdtq_pkg::*;;
  logic             valid;
  logic             ready;
  logic             result_kind;
  logic             status;
  logic [TAG_W-1:0] expired_tag;
  logic             last;

  modport source (output valid, output result_kind, output status, output expired_tag,
                  output last, input ready);
  modport sink   (input valid, input result_kind, input status, input expired_tag,
                  input last, output ready);
endinterface
`default_nettype wire

// File: rtl/sdtq_cell.sv
// one queue cell: holds an event, takes part in insert waves and head pops
`default_nettype none
module sdtq_cell import sdtq_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [TIME_W-1:0] now,
  input  logic [CNT_W-1:0]  count,
  input  logic              pop,
  input  carry_t            carry_in,
  input  ent_t              ent_next,
  output carry_t            carry_out,
  output ent_t              ent_out,
  output logic              fill
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  ent_t              ent_r, ent_nxt;
  carry_t            carry_r, carry_nxt;
  logic              occupied;
  logic [TIME_W-1:0] ent_dist;
  logic [TIME_W-1:0] car_dist;

  assign occupied = IDX_C < count;
  assign ent_dist = ent_r.dl - now;
  assign car_dist = carry_in.dl - now;

  always_comb begin
    ent_nxt   = ent_r;
    carry_nxt = '0;
    fill      = 1'b0;
    if (pop) begin
      ent_nxt = ent_next;
    end else if (carry_in.vld) begin
      if (!occupied) begin
        // first free cell, wave ends here
        ent_nxt = '{dl: carry_in.dl, tag: carry_in.tag};
        fill    = 1'b1;
      end else if (carry_in.shift || ent_dist > car_dist) begin
        // take the incoming event, push ours down the row
        ent_nxt   = '{dl: carry_in.dl, tag: carry_in.tag};
        carry_nxt = '{vld: 1'b1, shift: 1'b1, dl: ent_r.dl, tag: ent_r.tag};
      end else begin
        carry_nxt = carry_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r.vld <= 1'b0;
    end else begin
      carry_r <= carry_nxt;
    end
  end

  assign carry_out = carry_r;
  assign ent_out   = ent_r;

endmodule
`default_nettype wire

// File: rtl/sorted_deadline_timer_queue_top.sv
// top level of the sorted deadline timer queue
// A timer queue holding up to QUEUE_DEPTH events sorted by deadline, earliest at
// the head of a row of cells. An add item (func 0) stores deadline = time + timeout
// behind any equal deadlines and answers with one status item, in the cycle after
// it is taken (status 1 and nothing stored when the queue is full). Its insert then
// travels down the row one cell per cycle up to the first free cell; the next item
// is taken only once it has landed, which takes longer the more events are held.
// A tick item (func 1) advances the time counter by one and then pops every due
// event from the head, one result item per cycle while the receiver takes them,
// at most 16 per tick, the final one marked last; a tick that finds nothing due
// gives no result. Ordering and the due test use the distance of a deadline from
// the current time, so the 32-bit time counter may wrap. A result that waits on
// the receiver holds the input back; the next item enters only once the result
// register is empty or its item is taken in the same cycle. No clearing pass is
// needed after reset.
`default_nettype none
`include "sorted_deadline_timer_queue_top_assert.svh"
module sorted_deadline_timer_queue_top import sdtq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QD_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sdtq_in_if.sink   in_ch,
  sdtq_out_if.source out_ch
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  // control state
  state_t             state_r, state_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [POP_W-1:0]   pop_cnt_r, pop_cnt_nxt;

  // result register
  logic               out_vld_r, out_vld_nxt;
  logic               out_kind_r, out_kind_nxt;
  logic               out_status_r, out_status_nxt;
  logic [TAG_W-1:0]   out_tag_r, out_tag_nxt;
  logic               out_last_r, out_last_nxt;

  // cell row
  carry_t             carry [QUEUE_DEPTH+1];
  ent_t               ents  [QUEUE_DEPTH];
  ent_t               ent_nx [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] fills;
  logic [QUEUE_DEPTH-1:0] cvld;

  logic               slot_free;
  logic               busy;
  logic               in_acc;
  logic               q_full;
  logic               pop;
  logic               head_due;
  logic               next_due;
  logic               pop_last;

  assign slot_free = !out_vld_r || out_ch.ready;
  assign busy      = |cvld;
  assign in_ch.ready = (state_r == ST_IDLE) && slot_free && !busy;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign q_full    = count_r == FULL_CNT;

  // insert wave enters cell 0 in the cycle the add is taken
  always_comb begin
    carry[0]     = '0;
    carry[0].vld = in_acc && (in_ch.func == FUNC_ADD) && !q_full;
    carry[0].dl  = now_r + TIME_W'(in_ch.timeout);
    carry[0].tag = in_ch.event_tag;
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign ent_nx[i] = '0;
    end else begin : g_mid
      assign ent_nx[i] = ents[i+1];
    end
    assign cvld[i] = carry[i+1].vld;

    sdtq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .now       (now_r),
      .count     (count_r),
      .pop       (pop),
      .carry_in  (carry[i]),
      .ent_next  (ent_nx[i]),
      .carry_out (carry[i+1]),
      .ent_out   (ents[i]),
      .fill      (fills[i])
    );
  end

  // head and its follower, checked against the advanced time
  assign head_due = (count_r != '0) && is_due(ents[0].dl, now_r);
  assign next_due = (count_r > CNT_W'(1)) && is_due(ents[1].dl, now_r);
  assign pop_last = (pop_cnt_r == POP_W'(MAX_RESULTS - 1)) || !next_due;

  always_comb begin
    state_nxt      = state_r;
    now_nxt        = now_r;
    pop_cnt_nxt    = pop_cnt_r;
    pop            = 1'b0;
    out_vld_nxt    = out_vld_r && !out_ch.ready;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.func == FUNC_TICK) begin
            now_nxt     = now_r + TIME_W'(1);
            pop_cnt_nxt = '0;
            state_nxt   = ST_POP;
          end else begin
            // add answered right away, insert runs on in the row
            out_vld_nxt    = 1'b1;
            out_kind_nxt   = KIND_STATUS;
            out_status_nxt = q_full ? STATUS_FULL : STATUS_OK;
            out_tag_nxt    = '0;
            out_last_nxt   = 1'b1;
          end
        end
      end
      ST_POP: begin
        if (!head_due) begin
          // nothing due on this tick
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          pop            = 1'b1;
          out_vld_nxt    = 1'b1;
          out_kind_nxt   = KIND_EXPIRED;
          out_status_nxt = STATUS_OK;
          out_tag_nxt    = ents[0].tag;
          out_last_nxt   = pop_last;
          pop_cnt_nxt    = pop_cnt_r + POP_W'(1);
          if (pop_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // entry count moves when a wave lands or the head leaves
  always_comb begin
    count_nxt = count_r;
    if (|fills) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      now_r     <= '0;
      count_r   <= '0;
      pop_cnt_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      now_r     <= now_nxt;
      count_r   <= count_nxt;
      pop_cnt_r <= pop_cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.expired_tag = out_tag_r;
  assign out_ch.last        = out_last_r;

  // checks
  `SDTQ_ASSERT_IMP(a_one_wave, clk, rst_n, 1'b1, $onehot0(cvld), "more than one insert wave")
  `SDTQ_ASSERT_IMP(a_no_pop_in_wave, clk, rst_n, pop, !busy && !(|fills), "pop during insert")
  `SDTQ_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_r <= FULL_CNT, "entry count overflow")
  `SDTQ_ASSERT_NXT(a_tick_adv, clk, rst_n, in_acc && (in_ch.func == FUNC_TICK),
                   (state_r == ST_POP) && (now_r == $past(now_r) + TIME_W'(1)),
                   "tick did not advance time")

endmodule
`default_nettype wire

// File: tb/testbench.sv
// testbench for the sorted deadline timer queue: adds and ticks checked against a predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sdtq_pkg::*;

  localparam int unsigned DEPTH        = QD_DEPTH_DEF;
  // worst run is a few hundred items, each at most one full insert wave or 16
  // expiries under receiver stalls, so this is many times the slowest pass
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // after the last result the row may still be shifting an insert
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned IDLE_PCT     = 18;
  localparam int unsigned RANDOM_ITEMS = 265;
  localparam int unsigned QUIET_ITEMS  = 80;

  // one result item as the block should present it
  typedef struct {
    logic             kind;
    logic             status;
    logic [TAG_W-1:0] tag;
    logic             last;
  } timer_result_t;

  logic clk;
  logic rst_n;

  sdtq_in_if  in_ch ();
  sdtq_out_if out_ch ();

  sorted_deadline_timer_queue_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predicted queue contents, kept sorted by distance from now_ticks
  logic [TIME_W-1:0] now_ticks;
  logic [TIME_W-1:0] pend_deadline [DEPTH];
  logic [TAG_W-1:0]  pend_tag      [DEPTH];
  int unsigned       pend_count;

  // results predicted but not yet seen on the output channel
  timer_result_t awaited_results[$];

  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned cycle_count;
  // set while neither side may idle
  bit          no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // deadline at or before t, judged by the signed distance
  function automatic bit deadline_reached(logic [TIME_W-1:0] dl, logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] gap;
    gap = dl - t;
    return (gap == '0) || gap[TIME_W-1];
  endfunction

  // add: one status item; insert behind every equal deadline unless full
  function automatic void timer_insert(logic [TOUT_W-1:0] timeout, logic [TAG_W-1:0] tag);
    logic [TIME_W-1:0] ahead;
    int unsigned       pos;
    int unsigned       i;
    timer_result_t     res;
    res.kind = KIND_STATUS;
    res.tag  = '0;
    res.last = 1'b1;
    if (pend_count >= DEPTH) begin
      // dropped, state untouched
      res.status = STATUS_FULL;
      awaited_results.push_back(res);
      return;
    end
    ahead = TIME_W'(timeout);
    pos   = 0;
    while (pos < pend_count && (pend_deadline[pos] - now_ticks) <= ahead) pos++;
    for (i = pend_count; i > pos; i--) begin
      pend_deadline[i] = pend_deadline[i-1];
      pend_tag[i]      = pend_tag[i-1];
    end
    pend_deadline[pos] = now_ticks + ahead;
    pend_tag[pos]      = tag;
    pend_count++;
    res.status = STATUS_OK;
    awaited_results.push_back(res);
  endfunction

  // tick: advance time, then pop every due event from the head
  function automatic void timer_advance();
    timer_result_t fired[$];
    timer_result_t res;
    int unsigned   i;
    now_ticks = now_ticks + 1'b1;
    while (fired.size() < MAX_RESULTS && pend_count > 0 &&
           deadline_reached(pend_deadline[0], now_ticks)) begin
      res.kind   = KIND_EXPIRED;
      res.status = STATUS_OK;
      res.tag    = pend_tag[0];
      res.last   = 1'b0;
      fired.push_back(res);
      for (i = 1; i < pend_count; i++) begin
        pend_deadline[i-1] = pend_deadline[i];
        pend_tag[i-1]      = pend_tag[i];
      end
      pend_count--;
    end
    // nothing due means no result at all
    if (fired.size() > 0) fired[fired.size()-1].last = 1'b1;
    foreach (fired[k]) awaited_results.push_back(fired[k]);
  endfunction

  // drive one item, hold it until taken, then update the prediction;
  // valid stays high so back-to-back items need no second assignment
  task automatic send_item(logic func, logic [TOUT_W-1:0] timeout, logic [TAG_W-1:0] tag);
    while (!no_idle && $urandom_range(99, 0) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= func;
    in_ch.timeout   <= timeout;
    in_ch.event_tag <= tag;
    do @(posedge clk); while (!in_ch.ready);
    if (func == FUNC_ADD) timer_insert(timeout, tag);
    else timer_advance();
    items_sent++;
  endtask

  task automatic add_event(logic [TOUT_W-1:0] timeout, logic [TAG_W-1:0] tag);
    send_item(FUNC_ADD, timeout, tag);
  endtask

  // payload of a tick is ignored by the block, so it is random here
  task automatic tick();
    send_item(FUNC_TICK, TOUT_W'($urandom), TAG_W'($urandom));
  endtask

  // zero timeout expires on the very next tick; tags at both extremes
  task automatic test_zero_timeout();
    add_event('0, 16'h0000);
    tick();
    add_event('0, 16'hFFFF);
    add_event('0, 16'h8001);
    tick();
  endtask

  // equal deadlines keep arrival order, an earlier one jumps ahead
  task automatic test_equal_deadlines();
    add_event(24'd3, 16'h1111);
    add_event(24'd3, 16'h2222);
    add_event(24'd1, 16'h3333);
    add_event(24'd3, 16'h4444);
    tick();
    tick();
    tick();
  endtask

  // ticks with nothing due give no result
  task automatic test_idle_ticks();
    tick();
    tick();
  endtask

  // bursts of short-timeout adds followed by runs of ticks: fills the
  // queue at times, fires several events per tick, mixes in later deadlines
  task automatic test_random_traffic();
    int unsigned start;
    int unsigned n_add;
    int unsigned n_tick;
    logic [TOUT_W-1:0] tout;
    start   = items_sent;
    no_idle = 1'b1;
    while (items_sent < start + RANDOM_ITEMS) begin
      // first stretch runs with both sides always active
      if (items_sent >= start + QUIET_ITEMS) no_idle = 1'b0;
      n_add = $urandom_range(18, 1);
      repeat (n_add) begin
        if ($urandom_range(9, 0) == 0) tout = TOUT_W'($urandom_range(1023, 0));
        else tout = TOUT_W'($urandom_range(24, 0));
        add_event(tout, TAG_W'($urandom));
      end
      n_tick = $urandom_range(24, 1);
      repeat (n_tick) tick();
    end
    no_idle = 1'b0;
  endtask

  // far deadlines, including the largest timeout, fill the queue; one more
  // add is dropped as full; these events never fire within the run
  task automatic test_far_deadlines_fill();
    add_event(24'hFFFFFF, 16'hFFFF);
    while (pend_count < DEPTH)
      add_event(TOUT_W'($urandom_range(24'hFFFFFF, 24'h100000)), TAG_W'($urandom));
    add_event(TOUT_W'($urandom_range(24'hFFFFFF, 24'h100000)), 16'h0000);
    tick();
    tick();
  endtask

  // output side: compare every accepted result with the oldest prediction,
  // then pick the ready level for the next edge
  always @(posedge clk) begin
    timer_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result item: result_kind %0d expired_tag %h",
               out_ch.result_kind, out_ch.expired_tag);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.result_kind !== want.kind) begin
          $error("result_kind mismatch: expected %0d, actual %0d", want.kind, out_ch.result_kind);
          fail_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.expired_tag !== want.tag) begin
          $error("expired_tag mismatch: expected %h, actual %h", want.tag, out_ch.expired_tag);
          fail_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, out_ch.last);
          fail_count++;
        end
      end
    end
    out_ch.ready <= no_idle || ($urandom_range(99, 0) >= IDLE_PCT);
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    // every input known from time zero
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_ADD;
    in_ch.timeout   = '0;
    in_ch.event_tag = '0;
    out_ch.ready    = 1'b0;
    now_ticks       = '0;
    pend_count      = 0;
    fail_count      = 0;
    items_sent      = 0;
    no_idle         = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_zero_timeout();
    test_equal_deadlines();
    test_idle_ticks();
    test_random_traffic();
    test_far_deadlines_fill();
    in_ch.valid <= 1'b0;

    // wait out every predicted result, then give any stray one time to show
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
